// File: sv/gbn_pkg.sv
// shared types and constants for the go-back-n sender window
// no dependencies; compiled before every other file

package gbn_pkg;

  localparam int MAX_WINDOW = 16;
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int SEQ_W      = 16;
  localparam int WIN_W      = 5;
  localparam int TICK_W     = 32;
  localparam int ACK_W      = 17;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 4;

  typedef logic [SEQ_W-1:0]  seq_t;
  typedef logic [TICK_W-1:0] tick_t;

  // event kinds
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_ACK   = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_WINDOW_SIZE   = 2'd0,
    REG_PACKET_COUNT  = 2'd1,
    REG_TIMEOUT_TICKS = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEND
  } state_t;

endpackage

// File: sv/gbn_if.sv
// valid/ready channel interfaces for events in and frames out
// depends on gbn_pkg

interface gbn_event_if;
  import gbn_pkg::*;

  logic              valid;
  logic              ready;
  op_t               operation;
  logic signed [ACK_W-1:0] ack_seq;

  modport source (output valid, operation, ack_seq, input ready);
  modport sink   (input valid, operation, ack_seq, output ready);
endinterface

interface gbn_frame_if;
  import gbn_pkg::*;

  logic valid;
  logic ready;
  seq_t send_seq;
  logic is_retransmit;
  seq_t window_base;
  logic last;

  modport source (output valid, send_seq, is_retransmit, window_base, last, input ready);
  modport sink   (input valid, send_seq, is_retransmit, window_base, last, output ready);
endinterface

// File: sv/gbn_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies

module gbn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/go_back_n_sender_window.sv
// go-back-n arq sender window, top level
// depends on gbn_pkg, gbn_if (gbn_event_if, gbn_frame_if) and gbn_ram

// Go-Back-N sender. Events come in on req (start, cumulative acknowledgement,
// time tick); frames to transmit leave on rsp, one transfer per frame, with
// last set on the final frame an event causes. Events that send nothing give
// no transfer at all. Retransmit deadlines live in a 16-entry ram indexed by
// sequence number mod 16 with registered read data. An event is accepted
// only in ST_IDLE; a tick then reads the base frame's deadline in ST_CHECK,
// and each frame is loaded into the output register once it is free, so rsp
// back-pressure stalls sending. A new event is taken only once the previous
// one has issued all its frames; the last frame may still sit in the output
// register while the next event is accepted. Registers sit at byte addresses
// 0 (window_size), 4 (packet_count) and 8 (timeout_ticks); the user must
// write them only while the block is idle; the block does not enforce this.

module go_back_n_sender_window (
  input  logic                      clk,
  input  logic                      rst,
  gbn_event_if.sink                 req,
  gbn_frame_if.source               rsp,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [gbn_pkg::ADDR_W-1:0] paddr,
  input  logic [gbn_pkg::DATA_W-1:0] pwdata,
  output logic [gbn_pkg::DATA_W-1:0] prdata,
  output logic                      pready
);
  import gbn_pkg::*;

  // configuration registers
  logic [WIN_W-1:0] window_size;
  seq_t             packet_count;
  logic [15:0]      timeout_ticks;

  // sender state
  state_t state, state_next;
  seq_t   base_seq;
  seq_t   next_seq;
  tick_t  tick_clock;
  logic   started;
  logic   retx;

  // output register
  logic   out_valid;
  seq_t   out_seq;
  logic   out_retx;
  seq_t   out_base;
  logic   out_last;

  // deadline ram ports
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  tick_t             mem_wdata;
  tick_t             mem_rdata;

  logic             cfg_write;
  reg_idx_t         cfg_idx;
  logic             accept;
  logic [WIN_W-1:0] eff_win;
  logic [SEQ_W:0]   win_limit;
  logic [SEQ_W:0]   seq_plus1;
  logic             fits;
  logic             frame_last;
  logic             load_ok;
  logic             emit;
  seq_t             ack_val;
  logic             ack_ok;
  logic             tick_due;
  tick_t            age;
  logic             expired;

  // ---------------------------------------------------------------------
  // apb register port
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_idx   = reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= WIN_W'(4);
      packet_count  <= SEQ_W'(10);
      timeout_ticks <= 16'd2000;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_WINDOW_SIZE:   window_size   <= pwdata[WIN_W-1:0];
        REG_PACKET_COUNT:  packet_count  <= pwdata[SEQ_W-1:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WINDOW_SIZE:   prdata = DATA_W'(window_size);
      REG_PACKET_COUNT:  prdata = DATA_W'(packet_count);
      REG_TIMEOUT_TICKS: prdata = DATA_W'(timeout_ticks);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // window arithmetic
  // ---------------------------------------------------------------------
  // window of zero acts as one, anything above the slot count is clamped
  always_comb begin
    if (window_size == '0) begin
      eff_win = WIN_W'(1);
    end else if (window_size > WIN_W'(MAX_WINDOW)) begin
      eff_win = WIN_W'(MAX_WINDOW);
    end else begin
      eff_win = window_size;
    end
  end

  assign win_limit  = {1'b0, base_seq} + (SEQ_W+1)'(eff_win);
  assign seq_plus1  = {1'b0, next_seq} + 1'b1;
  assign fits       = ({1'b0, next_seq} < win_limit) && (next_seq < packet_count);
  // the frame after this one would not fit, so this one closes the event
  assign frame_last = (seq_plus1 >= win_limit) || (seq_plus1 >= {1'b0, packet_count});

  // output register frees up when empty or being drained this cycle
  assign load_ok = !out_valid || rsp.ready;
  assign accept  = req.valid && req.ready;

  // acknowledgement must be non-negative, at or above base and already sent
  assign ack_val = req.ack_seq[SEQ_W-1:0];
  assign ack_ok  = started && !req.ack_seq[ACK_W-1] &&
                   (ack_val >= base_seq) && (ack_val < next_seq);
  assign tick_due = started && (base_seq < next_seq);

  // deadline reached when clock minus deadline is below half the range
  assign age     = tick_clock - mem_rdata;
  assign expired = !age[TICK_W-1];

  // ---------------------------------------------------------------------
  // state machine
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req.operation)
            OP_START: state_next = ST_SEND;
            OP_ACK:   state_next = ack_ok ? ST_SEND : ST_IDLE;
            OP_TICK:  state_next = tick_due ? ST_CHECK : ST_IDLE;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_CHECK: begin
        state_next = expired ? ST_SEND : ST_IDLE;
      end
      ST_SEND: begin
        if (!fits) begin
          state_next = ST_IDLE;
        end else if (load_ok && frame_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == ST_IDLE);
    emit      = (state == ST_SEND) && fits && load_ok;
    mem_we    = emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------
  // sender state updates
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      started    <= 1'b0;
      base_seq   <= '0;
      next_seq   <= '0;
      tick_clock <= '0;
      retx       <= 1'b0;
    end else begin
      if (accept) begin
        case (req.operation)
          OP_START: begin
            started <= 1'b1;
            retx    <= 1'b0;
          end
          OP_ACK: begin
            retx <= 1'b0;
            if (ack_ok) begin
              base_seq <= ack_val + 1'b1;
            end
          end
          OP_TICK: begin
            tick_clock <= tick_clock + 1'b1;
          end
          default: ;
        endcase
      end
      // timeout rewind: resend from the base
      if (state == ST_CHECK && expired) begin
        next_seq <= base_seq;
        retx     <= 1'b1;
      end
      if (emit) begin
        next_seq <= next_seq + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // deadline memory, slot = sequence number mod window slots
  // ---------------------------------------------------------------------
  assign mem_waddr = next_seq[SLOT_W-1:0];
  assign mem_wdata = tick_clock + TICK_W'(timeout_ticks);

  // no write occurs while idle, so the read issued on a tick transfer
  // already sees every deadline written before it
  gbn_ram #(
    .WIDTH (TICK_W),
    .DEPTH (MAX_WINDOW)
  ) u_deadline_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (base_seq[SLOT_W-1:0]),
    .rdata (mem_rdata)
  );

  // ---------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_seq  <= next_seq;
      out_retx <= retx;
      out_base <= base_seq;
      out_last <= frame_last;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.send_seq      = out_seq;
  assign rsp.is_retransmit = out_retx;
  assign rsp.window_base   = out_base;
  assign rsp.last          = out_last;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  // base never passes the next frame to send
  a_base_order: assert property (@(posedge clk) disable iff (rst)
    base_seq <= next_seq)
    else $error("window base ahead of next sequence");

  // outstanding frames never exceed the slot count
  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, next_seq} - {1'b0, base_seq}) <= (SEQ_W+1)'(MAX_WINDOW))
    else $error("outstanding frames exceed window slots");

  // a deadline is only checked when a sent frame is outstanding
  a_check_outstanding: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHECK |-> base_seq < next_seq)
    else $error("deadline check with empty window");

  // the closing frame of an event returns the block to idle
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    emit && frame_last |=> state == ST_IDLE && out_last)
    else $error("event did not close after its last frame");

  // a frame written to the output register carries the updated base
  a_emit_base: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid && out_base == $past(base_seq))
    else $error("frame base mismatch");

endmodule
